### hdl/lscpg_pkg.sv
package lscpg_pkg;

  localparam int unsigned OpsW       = 48;
  localparam int unsigned LenW       = 5;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned PosW       = 16;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned MaxRuleLen = 16;
  localparam int unsigned OpBudget   = 65536;
  localparam int unsigned BudgetW    = $clog2(OpBudget + 1);

  localparam logic [OpsW-1:0] RuleZeroOpsRst = 48'd1615606817;
  localparam logic [LenW-1:0] RuleZeroLenRst = 5'd11;
  localparam logic [OpsW-1:0] RuleOneOpsRst  = 48'd2553299482;
  localparam logic [LenW-1:0] RuleOneLenRst  = 5'd11;
  localparam logic [LenW-1:0] CurveOrderRst  = 5'd4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RULE_ZERO_OPS = 3'd0,
    REG_RULE_ZERO_LEN = 3'd1,
    REG_RULE_ONE_OPS  = 3'd2,
    REG_RULE_ONE_LEN  = 3'd3,
    REG_CURVE_ORDER   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_FORWARD    = 3'd0,
    OP_TURN_LEFT  = 3'd1,
    OP_TURN_RIGHT = 3'd2,
    OP_CALL_ZERO  = 3'd3,
    OP_CALL_ONE   = 3'd4
  } op_e;

  typedef struct packed {
    logic            rule;
    logic [LenW-1:0] pos;
  } frame_t;

  function automatic logic [LenW-1:0] clip_len(input logic [LenW-1:0] len);
    clip_len = (len > LenW'(MaxRuleLen)) ? LenW'(MaxRuleLen) : len;
  endfunction

endpackage

### hdl/lsystem_curve_point_generator_top.sv
// Channel  | Dir | tdata (low bit up)                        | tuser
// s_axis   | in  | restart [0], zero fill to 8 bits          | -
// m_axis   | out | point_x [15:0], point_y [31:16],          | point_valid [0]
//          |     | raster_address [63:32]                    |
// cfg      | in  | cfg_we_i, cfg_index_i, cfg_wdata_i (48 bits), no read-back
//
// One op of the walk runs per cycle in the sequencer, except where a pop also waits in ST_LOAD
// for the stack memory read or stays in ST_RUN to see the empty stack; ST_FIN then loads
// the result register, after which the sequencer is idle again.
// s_axis_tready_o is high only while the sequencer is idle; the result register holds
// one finished point, so a stalled m_axis blocks the next result, not the next transfer.
// Reset clears the walk and loads the Hilbert rules with order 4.
module lsystem_curve_point_generator_top #(
  parameter int unsigned STACK_DEPTH = lscpg_pkg::StackDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [7:0]                     s_axis_tdata_i,   // restart
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [63:0]                    m_axis_tdata_o,   // point_x, point_y, raster_address
  output logic [0:0]                     m_axis_tuser_o,   // point_valid
  input  logic                           cfg_we_i,
  input  logic [lscpg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lscpg_pkg::OpsW-1:0]     cfg_wdata_i
);

  localparam int unsigned HW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = (HW > lscpg_pkg::LenW) ? HW : lscpg_pkg::LenW;
  localparam int unsigned LW = lscpg_pkg::LenW;
  localparam int unsigned PW = lscpg_pkg::PosW;
  localparam int unsigned BW = lscpg_pkg::BudgetW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LOAD,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_NOT_STARTED,
    PH_WALKING,
    PH_FINISHED
  } phase_e;

  logic [lscpg_pkg::OpsW-1:0] rule_zero_ops_q, rule_one_ops_q;
  logic [LW-1:0]              rule_zero_len_q, rule_one_len_q, curve_order_q;

  state_e            state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [HW-1:0]     height_q, height_d;
  lscpg_pkg::frame_t top_q, top_d;
  logic [PW-1:0]     pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [1:0]        heading_q, heading_d;
  logic [BW-1:0]     budget_q, budget_d;
  logic              res_valid_q, res_valid_d;
  logic              m_valid_q, m_valid_d;
  logic [63:0]       m_data_q, m_data_d;
  logic              m_user_q, m_user_d;

  lscpg_pkg::frame_t frame_mem [STACK_DEPTH];
  lscpg_pkg::frame_t rd_frame_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  lscpg_pkg::frame_t mem_wdata;

  logic                       s_xfer;
  logic [lscpg_pkg::OpsW-1:0] cur_ops, op_shift;
  logic [LW-1:0]              cur_len;
  logic [2:0]                 op;
  logic                       push_ok;
  logic [lscpg_pkg::AddrW-1:0] x_ext, y_ext, raster;

  assign s_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign cur_ops   = top_q.rule ? rule_one_ops_q : rule_zero_ops_q;
  assign cur_len   = lscpg_pkg::clip_len(top_q.rule ? rule_one_len_q : rule_zero_len_q);
  assign op_shift  = cur_ops >> (7'(top_q.pos) * 7'd3);
  assign op        = op_shift[2:0];
  assign push_ok   = (CW'(height_q) < CW'(curve_order_q)) &&
                     (height_q < HW'(STACK_DEPTH));
  assign x_ext     = {{(lscpg_pkg::AddrW - PW){pos_x_q[PW-1]}}, pos_x_q};
  assign y_ext     = {{(lscpg_pkg::AddrW - PW){pos_y_q[PW-1]}}, pos_y_q};
  assign raster    = (y_ext << curve_order_q) + x_ext;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    height_d    = height_q;
    top_d       = top_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    heading_d   = heading_q;
    budget_d    = budget_q;
    res_valid_d = res_valid_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = AW'(height_q - HW'(1));
    mem_raddr   = AW'(height_q - HW'(2));
    mem_wdata   = '{rule: top_q.rule, pos: top_q.pos + LW'(1)};

    case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          budget_d = '0;
          state_d  = ST_FIN;
          if (s_axis_tdata_i[0] || (phase_q == PH_NOT_STARTED)) begin
            pos_x_d     = '0;
            pos_y_d     = '0;
            heading_d   = '0;
            top_d       = '{rule: 1'b0, pos: '0};
            height_d    = HW'(1);
            phase_d     = PH_WALKING;
            res_valid_d = 1'b1;
          end else if (phase_q == PH_FINISHED) begin
            res_valid_d = 1'b0;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (budget_q == BW'(lscpg_pkg::OpBudget)) begin
          res_valid_d = 1'b0;
          state_d     = ST_FIN;
        end else if (height_q == '0) begin
          phase_d     = PH_FINISHED;
          res_valid_d = 1'b0;
          state_d     = ST_FIN;
        end else begin
          budget_d = budget_q + BW'(1);
          if (top_q.pos >= cur_len) begin
            height_d = height_q - HW'(1);
            if (height_q > HW'(1)) begin
              mem_re  = 1'b1;
              state_d = ST_LOAD;
            end
          end else begin
            top_d.pos = top_q.pos + LW'(1);
            case (op)
              lscpg_pkg::OP_FORWARD: begin
                case (heading_q)
                  2'd0:    pos_x_d = pos_x_q + PW'(1);
                  2'd1:    pos_y_d = pos_y_q + PW'(1);
                  2'd2:    pos_x_d = pos_x_q - PW'(1);
                  default: pos_y_d = pos_y_q - PW'(1);
                endcase
                res_valid_d = 1'b1;
                state_d     = ST_FIN;
              end
              lscpg_pkg::OP_TURN_LEFT:  heading_d = heading_q + 2'd1;
              lscpg_pkg::OP_TURN_RIGHT: heading_d = heading_q + 2'd3;
              lscpg_pkg::OP_CALL_ZERO, lscpg_pkg::OP_CALL_ONE: begin
                if (push_ok) begin
                  mem_we   = 1'b1;
                  top_d    = '{rule: (op == lscpg_pkg::OP_CALL_ONE), pos: '0};
                  height_d = height_q + HW'(1);
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_LOAD: begin
        top_d   = rd_frame_q;
        state_d = ST_RUN;
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_user_d  = res_valid_q;
          m_data_d  = res_valid_q ? {raster, pos_y_q, pos_x_q} : '0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_zero_ops_q <= lscpg_pkg::RuleZeroOpsRst;
      rule_zero_len_q <= lscpg_pkg::RuleZeroLenRst;
      rule_one_ops_q  <= lscpg_pkg::RuleOneOpsRst;
      rule_one_len_q  <= lscpg_pkg::RuleOneLenRst;
      curve_order_q   <= lscpg_pkg::CurveOrderRst;
      state_q         <= ST_IDLE;
      phase_q         <= PH_NOT_STARTED;
      height_q        <= '0;
      top_q           <= '0;
      pos_x_q         <= '0;
      pos_y_q         <= '0;
      heading_q       <= '0;
      budget_q        <= '0;
      res_valid_q     <= 1'b0;
      m_valid_q       <= 1'b0;
      m_data_q        <= '0;
      m_user_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lscpg_pkg::REG_RULE_ZERO_OPS: rule_zero_ops_q <= cfg_wdata_i;
          lscpg_pkg::REG_RULE_ZERO_LEN: rule_zero_len_q <= cfg_wdata_i[LW-1:0];
          lscpg_pkg::REG_RULE_ONE_OPS:  rule_one_ops_q  <= cfg_wdata_i;
          lscpg_pkg::REG_RULE_ONE_LEN:  rule_one_len_q  <= cfg_wdata_i[LW-1:0];
          lscpg_pkg::REG_CURVE_ORDER:   curve_order_q   <= cfg_wdata_i[LW-1:0];
          default: ;
        endcase
      end
      state_q     <= state_d;
      phase_q     <= phase_d;
      height_q    <= height_d;
      top_q       <= top_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      heading_q   <= heading_d;
      budget_q    <= budget_d;
      res_valid_q <= res_valid_d;
      m_valid_q   <= m_valid_d;
      m_data_q    <= m_data_d;
      m_user_q    <= m_user_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_frame_q <= frame_mem[mem_raddr];
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  a_height_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    height_q <= HW'(STACK_DEPTH))
    else $error("stack height above depth");

  a_busy_after_xfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_o)
    else $error("ready while busy");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("invalid result with nonzero data");

  a_load_has_parent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (height_q != '0))
    else $error("refill with empty stack");

endmodule
